// ===== rtl/bmls_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared types and opcode constants for the byte memory load/store stage.
// No dependencies.
package bmls_pkg;

	localparam logic [3:0] OP_NONE = 4'd0;
	localparam logic [3:0] OP_LW   = 4'd1;
	localparam logic [3:0] OP_LH   = 4'd2;
	localparam logic [3:0] OP_LHU  = 4'd3;
	localparam logic [3:0] OP_LB   = 4'd4;
	localparam logic [3:0] OP_LBU  = 4'd5;
	localparam logic [3:0] OP_SW   = 4'd6;
	localparam logic [3:0] OP_SH   = 4'd7;
	localparam logic [3:0] OP_SB   = 4'd8;

	typedef struct packed {
		logic [3:0]         opcode;
		logic signed [31:0] address;
		logic [31:0]        store_data;
		logic [4:0]         dest_reg;
		logic               reg_write;
		logic               mem_to_reg;
	} cmd_t;

	typedef struct packed {
		logic [31:0]        load_data;
		logic signed [31:0] alu_result;
		logic [4:0]         dest_reg_out;
		logic               reg_write_out;
		logic               mem_to_reg_out;
		logic               range_error;
		logic               align_error;
		logic               halt;
	} result_t;

endpackage
`default_nettype wire

// ===== rtl/byte_memory_load_store_stage_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel    Ports                 Handshake
// command    cmd (cmd_t)           accepted at an edge with start high and busy low
// result     result (result_t)     valid for the one cycle that done is high
//
// For each item the accept edge reads (and for stores writes) one word row of
// the data memory; the next edge forms the result and raises done. busy stays
// high until that edge, so a load right after a store sees the stored bytes.
// After reset a clearing pass zeroes all ceil(MEM_BYTES/4) memory rows, one
// row a cycle, with busy high. The receiver cannot stall.
// Depends on bmls_pkg.
module byte_memory_load_store_stage_top #(
	parameter int MEM_BYTES = 1024
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	output logic                  busy,
	input  bmls_pkg::cmd_t        cmd,
	output logic                  done,
	output bmls_pkg::result_t     result
);

	localparam int ROWS = (MEM_BYTES + 3) / 4;
	localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam logic [31:0] MEM_LIMIT = 32'(MEM_BYTES);
	localparam logic [AW-1:0] LAST_ROW = AW'(ROWS - 1);

	// memory: one row per word, byte lane k holds the byte at offset k
	logic [3:0][7:0] mem [ROWS];

	logic            clr_q;
	logic [AW-1:0]   clr_idx_q;
	logic            valid_s1;
	logic            done_q;
	logic [3:0][7:0] rd_word_q;
	bmls_pkg::cmd_t  cmd_s1;
	logic            rerr_s1;
	logic            aerr_s1;
	bmls_pkg::result_t out_q;

	logic            accept;
	logic [2:0]      size;
	logic            is_load;
	logic            is_store;
	logic            rerr;
	logic            aerr;
	logic [31:0]     addr_u;
	logic [31:0]     limit;
	logic [AW-1:0]   row;
	logic [3:0]      wr_be;
	logic [3:0][7:0] wr_data;
	logic [31:0]     load_val;

	assign accept = start & ~busy;
	assign busy   = clr_q | valid_s1;
	assign addr_u = cmd.address;
	assign row    = addr_u[AW+1:2];

	always_comb begin
		size     = 3'd0;
		is_load  = 1'b0;
		is_store = 1'b0;
		unique case (cmd.opcode)
			bmls_pkg::OP_LW: begin
				size = 3'd4; is_load = 1'b1;
			end
			bmls_pkg::OP_LH, bmls_pkg::OP_LHU: begin
				size = 3'd2; is_load = 1'b1;
			end
			bmls_pkg::OP_LB, bmls_pkg::OP_LBU: begin
				size = 3'd1; is_load = 1'b1;
			end
			bmls_pkg::OP_SW: begin
				size = 3'd4; is_store = 1'b1;
			end
			bmls_pkg::OP_SH: begin
				size = 3'd2; is_store = 1'b1;
			end
			bmls_pkg::OP_SB: begin
				size = 3'd1; is_store = 1'b1;
			end
			default: begin
				size = 3'd0;
			end
		endcase
	end

	assign limit = MEM_LIMIT - {29'd0, size};
	assign rerr  = (is_load | is_store) & (addr_u[31] | (addr_u > limit));
	assign aerr  = ((size == 3'd4) & (addr_u[1:0] != 2'd0)) |
	               ((size == 3'd2) & addr_u[0]);

	// big-endian lane placement: lowest address takes the most significant byte
	always_comb begin
		wr_be   = 4'd0;
		wr_data = '0;
		for (int k = 0; k < 4; k++) begin
			wr_data[k] = cmd.store_data[8*(3-k) +: 8];
		end
		if (is_store && !rerr && !aerr) begin
			unique case (size)
				3'd4: wr_be = 4'hF;
				3'd2: begin
					wr_be = addr_u[1] ? 4'b1100 : 4'b0011;
					wr_data[{addr_u[1], 1'b0}] = cmd.store_data[15:8];
					wr_data[{addr_u[1], 1'b1}] = cmd.store_data[7:0];
				end
				default: begin
					wr_be = 4'b0001 << addr_u[1:0];
					wr_data[addr_u[1:0]] = cmd.store_data[7:0];
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_idx_q] <= '0;
		end else if (accept) begin
			for (int k = 0; k < 4; k++) begin
				if (wr_be[k]) begin
					mem[row][k] <= wr_data[k];
				end
			end
			rd_word_q <= mem[row];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
			valid_s1  <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == LAST_ROW) begin
					clr_q <= 1'b0;
				end
			end
			valid_s1 <= accept;
			done_q   <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= cmd;
			rerr_s1 <= rerr;
			aerr_s1 <= aerr;
		end
	end

	// pick and extend the loaded bytes of the row read at the accept edge
	always_comb begin
		load_val = 32'd0;
		unique case (cmd_s1.opcode)
			bmls_pkg::OP_LW:
				load_val = {rd_word_q[0], rd_word_q[1], rd_word_q[2], rd_word_q[3]};
			bmls_pkg::OP_LH: begin
				load_val[15:0] = {rd_word_q[{cmd_s1.address[1], 1'b0}],
				                  rd_word_q[{cmd_s1.address[1], 1'b1}]};
				load_val[31:16] = {16{load_val[15]}};
			end
			bmls_pkg::OP_LHU:
				load_val[15:0] = {rd_word_q[{cmd_s1.address[1], 1'b0}],
				                  rd_word_q[{cmd_s1.address[1], 1'b1}]};
			bmls_pkg::OP_LB: begin
				load_val[7:0]  = rd_word_q[cmd_s1.address[1:0]];
				load_val[31:8] = {24{load_val[7]}};
			end
			bmls_pkg::OP_LBU:
				load_val[7:0] = rd_word_q[cmd_s1.address[1:0]];
			default:
				load_val = 32'd0;
		endcase
		if (rerr_s1 || aerr_s1) begin
			load_val = 32'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			out_q.load_data      <= load_val;
			out_q.alu_result     <= cmd_s1.address;
			out_q.dest_reg_out   <= cmd_s1.dest_reg;
			out_q.reg_write_out  <= cmd_s1.reg_write;
			out_q.mem_to_reg_out <= cmd_s1.mem_to_reg;
			out_q.range_error    <= rerr_s1;
			out_q.align_error    <= aerr_s1;
			out_q.halt           <= rerr_s1 | aerr_s1;
		end
	end

	assign done   = done_q;
	assign result = out_q;

endmodule
`default_nettype wire
